### rtl/fisr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared constants and leading-zero helpers for the rsqrt datapath.
// ----------------------------------------------------------------------------
package fisr_pkg;

   localparam logic [31:0] MAGIC_SEED   = 32'h5f3759df;
   localparam logic [31:0] CANON_NAN    = 32'h7fc00000;
   localparam logic [31:0] ONE_HALF     = 32'h3f000000;
   localparam logic [31:0] THREE_HALVES = 32'h3fc00000;
   localparam int          Y_DEPTH      = 12;

   // leading zeros of a 48-bit product (48 when zero)
   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] n;
      logic       hit;
      n   = 6'd48;
      hit = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!hit && v[i]) begin
            n   = 6'(47 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   // leading zeros of a 28-bit sum (28 when zero)
   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] n;
      logic       hit;
      n   = 5'd28;
      hit = 1'b0;
      for (int i = 27; i >= 0; i--) begin
         if (!hit && v[i]) begin
            n   = 5'(27 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

endpackage
`default_nettype wire

### rtl/fast_inverse_square_root.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// Pipelined 1/sqrt(x) estimate: magic-constant seed plus one Newton step.
// ----------------------------------------------------------------------------
// Usage: a request is taken on every clock edge where start is high; busy is
// always low, so one request per cycle is sustained. Each request yields one
// result on the result ports, flagged by rsp_valid for a single cycle; the
// receiver cannot stall, and results come out in request order. The chain
// is one input register holding x and the integer seed, then four
// three-stage multipliers and one three-stage subtractor in series (x*0.5,
// *y, *y, 1.5-t, y*d), sixteen register stages in all. All float ops round
// to nearest even with full subnormal support; any NaN result is the
// canonical quiet NaN.
// ----------------------------------------------------------------------------
module fast_inverse_square_root (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_operand_bits,
   output logic             rsp_valid,
   output logic [31:0]      rsp_estimate_bits
);
   import fisr_pkg::*;

   // input register: x and the integer seed y
   logic        v0_ff;
   logic [31:0] x0_ff, y0_ff;
   logic [31:0] y0_in;

   // arithmetic shift right by one, then subtract from the magic seed
   assign y0_in = MAGIC_SEED - {req_operand_bits[31], req_operand_bits[31:1]};
   assign busy  = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start;
      end
      x0_ff <= req_operand_bits;
      y0_ff <= y0_in;
   end

   // seed delay line, tapped where each unit needs y
   logic [31:0] y_line_ff [Y_DEPTH];

   always_ff @(posedge clock) begin
      y_line_ff[0] <= y0_ff;
      for (int i = 1; i < Y_DEPTH; i++) begin
         y_line_ff[i] <= y_line_ff[i-1];
      end
   end

   logic        x2_v, t1_v, t2_v, d_v;
   logic [31:0] x2_b, t1_b, t2_b, d_b;

   // x2 = x * 0.5
   fisr_mul u_mul_half (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .in_a      (x0_ff),
      .in_b      (ONE_HALF),
      .out_valid (x2_v),
      .out_bits  (x2_b)
   );

   // t1 = x2 * y
   fisr_mul u_mul_t1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (x2_v),
      .in_a      (x2_b),
      .in_b      (y_line_ff[2]),
      .out_valid (t1_v),
      .out_bits  (t1_b)
   );

   // t2 = t1 * y
   fisr_mul u_mul_t2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t1_v),
      .in_a      (t1_b),
      .in_b      (y_line_ff[5]),
      .out_valid (t2_v),
      .out_bits  (t2_b)
   );

   // d = 1.5 - t2
   fisr_sub u_sub_d (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t2_v),
      .in_a      (THREE_HALVES),
      .in_b      (t2_b),
      .out_valid (d_v),
      .out_bits  (d_b)
   );

   // r = y * d, NaN already canonical out of the multiplier
   fisr_mul u_mul_r (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_v),
      .in_a      (y_line_ff[Y_DEPTH-1]),
      .in_b      (d_b),
      .out_valid (rsp_valid),
      .out_bits  (rsp_estimate_bits)
   );

endmodule
`default_nettype wire

### rtl/fisr_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fisr_mul
// Three-stage single-precision multiplier, round to nearest even, subnormals.
// ----------------------------------------------------------------------------
module fisr_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire logic [31:0] in_a,
   input  wire logic [31:0] in_b,
   output logic             out_valid,
   output logic [31:0]      out_bits
);
   import fisr_pkg::*;

   // stage 1: unpack and multiply
   logic        v1_ff, s1_ff, nan1_ff, inf1_ff, zero1_ff;
   logic [47:0] prod1_ff;
   logic [8:0]  esum1_ff;
   logic        nan1_in, inf1_in, zero1_in;
   logic [23:0] ma, mb;
   logic [7:0]  ea, eb;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

   always_comb begin
      a_nan  = (in_a[30:23] == 8'hff) && (in_a[22:0] != 23'd0);
      b_nan  = (in_b[30:23] == 8'hff) && (in_b[22:0] != 23'd0);
      a_inf  = (in_a[30:23] == 8'hff) && (in_a[22:0] == 23'd0);
      b_inf  = (in_b[30:23] == 8'hff) && (in_b[22:0] == 23'd0);
      a_zero = (in_a[30:0] == 31'd0);
      b_zero = (in_b[30:0] == 31'd0);
      ma     = {(in_a[30:23] != 8'd0), in_a[22:0]};
      mb     = {(in_b[30:23] != 8'd0), in_b[22:0]};
      ea     = (in_a[30:23] == 8'd0) ? 8'd1 : in_a[30:23];
      eb     = (in_b[30:23] == 8'd0) ? 8'd1 : in_b[30:23];
      nan1_in  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      inf1_in  = a_inf || b_inf;
      zero1_in = a_zero || b_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      s1_ff    <= in_a[31] ^ in_b[31];
      nan1_ff  <= nan1_in;
      inf1_ff  <= inf1_in;
      zero1_ff <= zero1_in;
      prod1_ff <= ma * mb;
      esum1_ff <= {1'b0, ea} + {1'b0, eb};
   end

   // stage 2: exponent and shift amount
   logic        v2_ff, s2_ff, nan2_ff, inf2_ff, zero2_ff, left2_ff, ovf2_ff;
   logic [47:0] prod2_ff;
   logic [6:0]  sh2_ff;
   logic [7:0]  e2_ff;
   logic [5:0]  lz;
   logic signed [11:0] e_full, sh_full;
   logic [6:0]  sh2_in;
   logic        left2_in;

   always_comb begin
      lz     = lzc48(prod1_ff);
      e_full = $signed({3'b0, esum1_ff}) - 12'sd126 - $signed({6'b0, lz});
      if (e_full >= 12'sd1) begin
         sh_full = 12'sd24 - $signed({6'b0, lz});
      end else begin
         sh_full = 12'sd25 - $signed({6'b0, lz}) - e_full;
      end
      left2_in = sh_full < 12'sd0;
      if (left2_in) begin
         sh2_in = 7'(-sh_full);
      end else if (sh_full > 12'sd72) begin
         sh2_in = 7'd72;
      end else begin
         sh2_in = 7'(sh_full);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      s2_ff    <= s1_ff;
      nan2_ff  <= nan1_ff;
      inf2_ff  <= inf1_ff;
      zero2_ff <= zero1_ff;
      prod2_ff <= prod1_ff;
      left2_ff <= left2_in;
      sh2_ff   <= sh2_in;
      ovf2_ff  <= e_full >= 12'sd255;
      e2_ff    <= (e_full >= 12'sd1) ? e_full[7:0] : 8'd1;
   end

   // stage 3: align, round, pack
   logic         v3_ff;
   logic [31:0]  bits3_ff;
   logic [119:0] xw;
   logic [23:0]  mm;
   logic         g, st, inc;
   logic [7:0]   eenc;
   logic [30:0]  rnd;
   logic [31:0]  bits3_in;

   always_comb begin
      if (left2_ff) begin
         xw = {prod2_ff, 72'd0} << sh2_ff;
      end else begin
         xw = {prod2_ff, 72'd0} >> sh2_ff;
      end
      mm   = xw[95:72];
      g    = xw[71];
      st   = |xw[70:0];
      inc  = g && (st || mm[0]);
      eenc = mm[23] ? e2_ff : 8'd0;
      rnd  = {eenc, mm[22:0]} + {30'd0, inc};
      if (nan2_ff) begin
         bits3_in = CANON_NAN;
      end else if (inf2_ff || (!zero2_ff && ovf2_ff)) begin
         bits3_in = {s2_ff, 8'hff, 23'd0};
      end else if (zero2_ff) begin
         bits3_in = {s2_ff, 31'd0};
      end else begin
         bits3_in = {s2_ff, rnd};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      bits3_ff <= bits3_in;
   end

   assign out_valid = v3_ff;
   assign out_bits  = bits3_ff;

endmodule
`default_nettype wire

### rtl/fisr_sub.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fisr_sub
// Three-stage single-precision subtractor a - b, round to nearest even.
// ----------------------------------------------------------------------------
module fisr_sub (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire logic [31:0] in_a,
   input  wire logic [31:0] in_b,
   output logic             out_valid,
   output logic [31:0]      out_bits
);
   import fisr_pkg::*;

   // stage 1: specials, order by magnitude
   logic        v1_ff, sl1_ff, esub1_ff, nan1_ff, inf1_ff, infs1_ff;
   logic [23:0] ml1_ff, ms1_ff;
   logic [7:0]  el1_ff, d1_ff;
   logic [31:0] bn, big, sml;
   logic        a_nan, b_nan, a_inf, b_inf, swap;
   logic [7:0]  eb_big, eb_sml;

   always_comb begin
      bn     = {~in_b[31], in_b[30:0]};
      a_nan  = (in_a[30:23] == 8'hff) && (in_a[22:0] != 23'd0);
      b_nan  = (bn[30:23] == 8'hff) && (bn[22:0] != 23'd0);
      a_inf  = (in_a[30:23] == 8'hff) && (in_a[22:0] == 23'd0);
      b_inf  = (bn[30:23] == 8'hff) && (bn[22:0] == 23'd0);
      swap   = bn[30:0] > in_a[30:0];
      big    = swap ? bn : in_a;
      sml    = swap ? in_a : bn;
      eb_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      eb_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      sl1_ff   <= big[31];
      esub1_ff <= in_a[31] ^ bn[31];
      nan1_ff  <= a_nan || b_nan || (a_inf && b_inf && (in_a[31] != bn[31]));
      inf1_ff  <= a_inf || b_inf;
      infs1_ff <= a_inf ? in_a[31] : bn[31];
      ml1_ff   <= {(big[30:23] != 8'd0), big[22:0]};
      ms1_ff   <= {(sml[30:23] != 8'd0), sml[22:0]};
      el1_ff   <= eb_big;
      d1_ff    <= eb_big - eb_sml;
   end

   // stage 2: align and add
   logic        v2_ff, sl2_ff, esub2_ff, nan2_ff, inf2_ff, infs2_ff;
   logic [27:0] sum2_ff;
   logic [7:0]  el2_ff;
   logic [53:0] shw;
   logic [26:0] al;
   logic [5:0]  dcl;

   always_comb begin
      dcl = (d1_ff > 8'd27) ? 6'd27 : d1_ff[5:0];
      shw = {ms1_ff, 3'b000, 27'd0} >> dcl;
      al  = {shw[53:28], shw[27] | (|shw[26:0])};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      sl2_ff   <= sl1_ff;
      esub2_ff <= esub1_ff;
      nan2_ff  <= nan1_ff;
      inf2_ff  <= inf1_ff;
      infs2_ff <= infs1_ff;
      el2_ff   <= el1_ff;
      sum2_ff  <= esub1_ff ? ({1'b0, ml1_ff, 3'b000} - {1'b0, al})
                           : ({1'b0, ml1_ff, 3'b000} + {1'b0, al});
   end

   // stage 3: normalize, round, pack
   logic        v3_ff;
   logic [31:0] bits3_ff;
   logic [4:0]  lz;
   logic [7:0]  shl;
   logic [27:0] lsh;
   logic [26:0] s27;
   logic [8:0]  ee;
   logic [23:0] mm;
   logic        inc;
   logic [7:0]  eenc;
   logic [30:0] rnd;
   logic [31:0] bits3_in;

   always_comb begin
      lz  = lzc28(sum2_ff);
      shl = 8'd0;
      lsh = sum2_ff;
      if (sum2_ff[27]) begin
         s27 = {sum2_ff[27:2], sum2_ff[1] | sum2_ff[0]};
         ee  = {1'b0, el2_ff} + 9'd1;
      end else begin
         shl = (({3'b0, lz} - 8'd1) < (el2_ff - 8'd1)) ? ({3'b0, lz} - 8'd1)
                                                       : (el2_ff - 8'd1);
         lsh = sum2_ff << shl;
         s27 = lsh[26:0];
         ee  = {1'b0, el2_ff - shl};
      end
      mm   = s27[26:3];
      inc  = s27[2] && ((|s27[1:0]) || mm[0]);
      eenc = mm[23] ? ee[7:0] : 8'd0;
      rnd  = {eenc, mm[22:0]} + {30'd0, inc};
      if (nan2_ff) begin
         bits3_in = CANON_NAN;
      end else if (inf2_ff) begin
         bits3_in = {infs2_ff, 8'hff, 23'd0};
      end else if (sum2_ff == 28'd0) begin
         bits3_in = {sl2_ff & ~esub2_ff, 31'd0};
      end else if (ee >= 9'd255) begin
         bits3_in = {sl2_ff, 8'hff, 23'd0};
      end else begin
         bits3_in = {sl2_ff, rnd};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      bits3_ff <= bits3_in;
   end

   assign out_valid = v3_ff;
   assign out_bits  = bits3_ff;

endmodule
`default_nettype wire
